/* sv/assert_macros.svh */
// Assertion helpers for the RTL, included by pklp_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, masked while reset is asserted
`define PKLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included
`define PKLP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* sv/pklp_pkg.sv */
package pklp_pkg;

  // Press counter width; the count saturates at all ones
  localparam int unsigned CountWidth = 16;
  localparam int unsigned ThreshWidth = 16;
  localparam int unsigned CmpWidth = (CountWidth > ThreshWidth) ? CountWidth : ThreshWidth;

  // Configuration register indexes
  typedef enum logic [1:0] {
    RegSleepTicks    = 2'd0,
    RegRestartTicks  = 2'd1,
    RegShutdownTicks = 2'd2,
    RegBootKeyHeld   = 2'd3
  } reg_idx_e;

  // Hold window reached during the current press
  typedef enum logic [1:0] {
    WinNone    = 2'd0,
    WinSleep   = 2'd1,
    WinRestart = 2'd2,
    WinShut    = 2'd3
  } win_e;

  typedef struct packed {
    logic [ThreshWidth-1:0] sleep_ticks;
    logic [ThreshWidth-1:0] restart_ticks;
    logic [ThreshWidth-1:0] shutdown_ticks;
    logic                   boot_key_held;
  } cfg_t;

  typedef struct packed {
    logic power_hold;
    logic shutdown_event;
    logic restart_request;
    logic wake_event;
    logic sleep_event;
    logic screen_off;
  } res_t;

endpackage

/* sv/pklp_cfg_regs.sv */
module pklp_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  pklp_pkg::reg_idx_e  cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i,
  output pklp_pkg::cfg_t      cfg_o
);

  pklp_pkg::cfg_t cfg_q;

  // Register file write decode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sleep_ticks    <= 16'd10;
      cfg_q.restart_ticks  <= 16'd60;
      cfg_q.shutdown_ticks <= 16'd100;
      cfg_q.boot_key_held  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pklp_pkg::RegSleepTicks:    cfg_q.sleep_ticks    <= cfg_wdata_i;
        pklp_pkg::RegRestartTicks:  cfg_q.restart_ticks  <= cfg_wdata_i;
        pklp_pkg::RegShutdownTicks: cfg_q.shutdown_ticks <= cfg_wdata_i;
        pklp_pkg::RegBootKeyHeld:   cfg_q.boot_key_held  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* sv/pklp_core.sv */
`include "assert_macros.svh"

module pklp_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pklp_pkg::cfg_t cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           key_i,
  input  logic           res_ready_i,
  output logic           res_valid_o,
  output pklp_pkg::res_t res_o
);

  localparam int unsigned CW = pklp_pkg::CountWidth;
  localparam int unsigned MW = pklp_pkg::CmpWidth;

  // Input stage
  logic in_valid_q;
  logic key_q;
  logic fire;

  assign fire       = in_valid_q && res_ready_i;
  assign in_ready_o = !in_valid_q || res_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      key_q <= key_i;
    end
  end

  // Controller state
  logic            armed_q, armed_d;
  pklp_pkg::win_e  win_q, win_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            dark_q, dark_d;
  logic            pwr_drop_q, pwr_drop_d;

  logic [CW-1:0]   cnt_inc;
  logic [MW-1:0]   cnt_ext;
  logic            ev_sleep, ev_wake, ev_restart, ev_shut;
  logic            toggle;

  assign cnt_inc = (cnt_q != {CW{1'b1}}) ? cnt_q + CW'(1) : cnt_q;
  assign cnt_ext = MW'(cnt_inc);

  // Per-tick update
  always_comb begin
    armed_d    = armed_q;
    win_d      = win_q;
    cnt_d      = cnt_q;
    dark_d     = dark_q;
    pwr_drop_d = pwr_drop_q;
    ev_sleep   = 1'b0;
    ev_wake    = 1'b0;
    ev_restart = 1'b0;
    ev_shut    = 1'b0;
    toggle     = 1'b0;
    if (cfg_i.boot_key_held) begin
      if (key_q) begin
        if (armed_q) begin
          cnt_d = cnt_inc;
          if (cnt_ext >= MW'(cfg_i.shutdown_ticks)) begin
            if (win_q != pklp_pkg::WinShut) begin
              win_d      = pklp_pkg::WinShut;
              pwr_drop_d = 1'b1;
              ev_shut    = 1'b1;
            end
          end else if (cnt_ext >= MW'(cfg_i.restart_ticks)) begin
            if (win_q == pklp_pkg::WinNone || win_q == pklp_pkg::WinSleep) begin
              win_d = pklp_pkg::WinRestart;
            end
          end else if (cnt_ext >= MW'(cfg_i.sleep_ticks)) begin
            if (win_q == pklp_pkg::WinNone) begin
              win_d = pklp_pkg::WinSleep;
            end
          end
        end
      end else begin
        if (!armed_q) begin
          armed_d = 1'b1;
        end else if (cnt_q != '0) begin
          case (win_q)
            pklp_pkg::WinShut:    toggle = 1'b0;
            pklp_pkg::WinRestart: ev_restart = 1'b1;
            pklp_pkg::WinSleep:   toggle = 1'b1;
            default:              toggle = MW'(cnt_q) < MW'(cfg_i.sleep_ticks);
          endcase
          if (toggle) begin
            dark_d   = !dark_q;
            ev_wake  = dark_q;
            ev_sleep = !dark_q;
          end
          win_d = pklp_pkg::WinNone;
        end
        cnt_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q    <= 1'b0;
      win_q      <= pklp_pkg::WinNone;
      cnt_q      <= '0;
      dark_q     <= 1'b0;
      pwr_drop_q <= 1'b0;
    end else if (fire) begin
      armed_q    <= armed_d;
      win_q      <= win_d;
      cnt_q      <= cnt_d;
      dark_q     <= dark_d;
      pwr_drop_q <= pwr_drop_d;
    end
  end

  // Result word
  assign res_valid_o           = fire;
  assign res_o.screen_off      = dark_d;
  assign res_o.sleep_event     = ev_sleep;
  assign res_o.wake_event      = ev_wake;
  assign res_o.restart_request = ev_restart;
  assign res_o.shutdown_event  = ev_shut;
  assign res_o.power_hold      = cfg_i.boot_key_held && !pwr_drop_d;

  `PKLP_ASSERT(a_pwr_drop_sticky, pwr_drop_q |=> pwr_drop_q, "power drop cleared before reset")
  `PKLP_ASSERT(a_shut_implies_drop, (win_q == pklp_pkg::WinShut) |-> pwr_drop_q, "shutdown window without power drop")
  `PKLP_ASSERT(a_count_needs_arm, !armed_q |-> (cnt_q == '0), "press counted before arming")

endmodule

/* sv/pklp_out_reg.sv */
module pklp_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           res_valid_i,
  output logic           res_ready_o,
  input  pklp_pkg::res_t res_i,
  output logic           m_valid_o,
  input  logic           m_ready_i,
  output pklp_pkg::res_t m_data_o
);

  logic           valid_q;
  pklp_pkg::res_t data_q;

  // Slot frees up when empty or drained this cycle
  assign res_ready_o = !valid_q || m_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_ready_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      data_q <= res_i;
    end
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = data_q;

endmodule

/* sv/power_key_long_press_controller.sv */
// Long-press power key controller. Each input word carries one debounced key
// sample (tdata bit 0, 1 = pressed) and yields exactly one result word: screen
// state, sleep/wake/restart/shutdown pulses and the power latch drive. A word
// is accepted every clock cycle unless the result side stalls. Its result word
// passes the input register, then the result register, before it is offered
// on the output. The key state update is a single compare-and-increment pass
// between the two registers. After reset the key is ignored until its first
// release. Holding it then counts ticks (saturating) through the sleep,
// restart and shutdown windows. Shutdown fires while still held and drops
// power_hold until reset. Write the threshold registers only while no words
// are in flight.
module power_key_long_press_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  // Key sample stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [0] key_down, [7:1] zero
  // Result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o    // [0] screen_off, [1] sleep_event,
                                        // [2] wake_event, [3] restart_request,
                                        // [4] shutdown_event, [5] power_hold
);

  pklp_pkg::cfg_t cfg;
  pklp_pkg::res_t res, res_q;
  logic           res_valid, res_ready;

  pklp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (pklp_pkg::reg_idx_e'(cfg_idx_i)),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pklp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .key_i       (s_axis_tdata_i[0]),
    .res_ready_i (res_ready),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  pklp_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .m_data_o    (res_q)
  );

  assign m_axis_tdata_o = {2'b00, res_q};

endmodule

/* dv/power_key_long_press_controller_tb.sv */
`timescale 1ns / 1ps

module power_key_long_press_controller_tb;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldOffCycles = 300;

  // Arming stages of the key handler
  localparam logic [1:0] ArmWaitRelease = 2'd1;
  localparam logic [1:0] ArmReady       = 2'd2;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;   // [0] key_down, [7:1] zero
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;        // [0] screen_off, [1] sleep_event,
                                      // [2] wake_event, [3] restart_request,
                                      // [4] shutdown_event, [5] power_hold

  power_key_long_press_controller dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // Key handler mirror: settings and press state
  pklp_pkg::cfg_t key_cfg = '{sleep_ticks: 16'd10, restart_ticks: 16'd60,
                              shutdown_ticks: 16'd100, boot_key_held: 1'b1};
  logic [1:0]                      arm_stage = ArmWaitRelease;
  pklp_pkg::win_e                  hold_window = pklp_pkg::WinNone;
  logic [pklp_pkg::CountWidth-1:0] press_cnt = '0;
  logic                            screen_dark = 1'b0;
  logic                            power_dropped = 1'b0;

  pklp_pkg::res_t pending_results[$];
  int   fail_cnt = 0;
  bit   idle_on = 1'b0;
  int   hold_off_left = 0;
  int   stall_left = 0;
  int   quiet_cycles = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Advance the mirrored key handler by one sample and queue its result word
  task automatic key_handler_step(input bit key);
    pklp_pkg::res_t r;
    bit             toggle;
    r = '0;
    toggle = 1'b0;
    if (key_cfg.boot_key_held &&
        (arm_stage == ArmWaitRelease || arm_stage == ArmReady)) begin
      if (key) begin
        if (arm_stage == ArmReady) begin
          if (press_cnt != '1) press_cnt = press_cnt + 1'b1;
          // shutdown is tested first; windows never move back during a press
          if (press_cnt >= key_cfg.shutdown_ticks) begin
            if (hold_window != pklp_pkg::WinShut) begin
              hold_window = pklp_pkg::WinShut;
              power_dropped = 1'b1;
              r.shutdown_event = 1'b1;
            end
          end else if (press_cnt >= key_cfg.restart_ticks) begin
            if (hold_window < pklp_pkg::WinRestart) hold_window = pklp_pkg::WinRestart;
          end else if (press_cnt >= key_cfg.sleep_ticks) begin
            if (hold_window == pklp_pkg::WinNone) hold_window = pklp_pkg::WinSleep;
          end
        end
      end else begin
        if (arm_stage == ArmWaitRelease) begin
          arm_stage = ArmReady;
        end else if (press_cnt != '0) begin
          case (hold_window)
            pklp_pkg::WinShut:    ;
            pklp_pkg::WinRestart: r.restart_request = 1'b1;
            default:              toggle = (press_cnt < key_cfg.sleep_ticks) ||
                                           (hold_window == pklp_pkg::WinSleep);
          endcase
          if (toggle) begin
            screen_dark = ~screen_dark;
            r.sleep_event = screen_dark;
            r.wake_event = ~screen_dark;
          end
          hold_window = pklp_pkg::WinNone;
        end
        press_cnt = '0;
      end
    end
    r.screen_off = screen_dark;
    r.power_hold = key_cfg.boot_key_held && !power_dropped;
    pending_results.push_back(r);
  endtask

  // Offer one key sample, with an occasional gap before it
  task automatic send_key(input bit key);
    int gap;
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 9);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {7'd0, key};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    key_handler_step(key);
  endtask

  task automatic send_press(input int hold);
    repeat (hold) send_key(1'b1);
    send_key(1'b0);
  endtask

  // Stop offering and let every outstanding word come back
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input pklp_pkg::reg_idx_e idx, input logic [15:0] val);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      pklp_pkg::RegSleepTicks:    key_cfg.sleep_ticks = val;
      pklp_pkg::RegRestartTicks:  key_cfg.restart_ticks = val;
      pklp_pkg::RegShutdownTicks: key_cfg.shutdown_ticks = val;
      pklp_pkg::RegBootKeyHeld:   key_cfg.boot_key_held = val[0];
      default: ;
    endcase
  endtask

  task automatic set_windows(input logic [15:0] slp, input logic [15:0] rst,
                             input logic [15:0] shut);
    write_reg(pklp_pkg::RegSleepTicks, slp);
    write_reg(pklp_pkg::RegRestartTicks, rst);
    write_reg(pklp_pkg::RegShutdownTicks, shut);
  endtask

  // Result side: random stall bursts plus the long hold-off
  always @(negedge clk_i) begin
    if (hold_off_left > 0) begin
      hold_off_left--;
      m_axis_tready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 8);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  function automatic void compare_field(input string name, input logic want, input logic got);
    if (got !== want) begin
      $error("%s mismatch: expected %0b, got %0b", name, want, got);
      fail_cnt++;
    end
  endfunction

  // Result checker against the oldest queued expectation
  always @(posedge clk_i) begin
    pklp_pkg::res_t got;
    pklp_pkg::res_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = pklp_pkg::res_t'(m_axis_tdata_o[5:0]);
      if (pending_results.size() == 0) begin
        $error("unexpected result word %h", m_axis_tdata_o);
        fail_cnt++;
      end else begin
        want = pending_results.pop_front();
        compare_field("screen_off", want.screen_off, got.screen_off);
        compare_field("sleep_event", want.sleep_event, got.sleep_event);
        compare_field("wake_event", want.wake_event, got.wake_event);
        compare_field("restart_request", want.restart_request, got.restart_request);
        compare_field("shutdown_event", want.shutdown_event, got.shutdown_event);
        compare_field("power_hold", want.power_hold, got.power_hold);
        compare_field("pad_bit6", 1'b0, m_axis_tdata_o[6]);
        compare_field("pad_bit7", 1'b0, m_axis_tdata_o[7]);
      end
    end
  end

  // Watchdog: too long with no word moving on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Handler disabled: nothing arms, power latch low
  task automatic test_disabled_at_boot();
    write_reg(pklp_pkg::RegBootKeyHeld, 16'd0);
    send_key(1'b1);
    send_key(1'b0);
    send_press(2);
    write_reg(pklp_pkg::RegBootKeyHeld, 16'd1);
  endtask

  // Held samples before the first release are ignored
  task automatic test_first_release_arms();
    send_key(1'b1);
    send_key(1'b1);
    send_key(1'b0);
    send_press(2);
  endtask

  // Zero-count release, then sleep, restart and shutdown windows
  task automatic test_hold_windows();
    set_windows(16'd2, 16'd4, 16'd7);
    send_key(1'b0);
    send_press(3);
    send_press(5);
    send_press(8);
  endtask

  // Thresholds moved during a press, and misordered thresholds
  task automatic test_config_changes();
    set_windows(16'd10, 16'd20, 16'd30);
    repeat (3) send_key(1'b1);
    write_reg(pklp_pkg::RegSleepTicks, 16'd2);
    send_key(1'b0);
    set_windows(16'd5, 16'd3, 16'd8);
    send_press(4);
    send_press(6);
  endtask

  task automatic test_min_thresholds();
    set_windows(16'd1, 16'd1, 16'd1);
    send_press(1);
    send_press(3);
    write_reg(pklp_pkg::RegShutdownTicks, 16'hFFFF);
    send_press(2);
  endtask

  // Thresholds at the top of the range: a normal hold reaches no window
  task automatic test_max_thresholds();
    set_windows(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_press(40);
    send_press(1);
  endtask

  function automatic logic [15:0] pick_threshold();
    case ($urandom_range(0, 11))
      0:       return 16'd1;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(2, 40));
    endcase
  endfunction

  // Random settings, mostly well-formed presses aimed at the windows
  task automatic test_random_phase(input int n_items, input bit pressure);
    logic [15:0] th[3];
    logic [15:0] tmp;
    int          sent;
    int          hold;
    int          target;
    for (int i = 0; i < 3; i++) th[i] = pick_threshold();
    if ($urandom_range(0, 3) != 0) begin
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 2 - i; j++)
          if (th[j] > th[j+1]) begin
            tmp = th[j];
            th[j] = th[j+1];
            th[j+1] = tmp;
          end
    end
    set_windows(th[0], th[1], th[2]);
    write_reg(pklp_pkg::RegBootKeyHeld, ($urandom_range(0, 5) == 0) ? 16'd0 : 16'd1);
    if (pressure) hold_off_left = HoldOffCycles;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          send_key(1'($urandom_range(0, 1)));
          sent++;
        end
      end else begin
        case ($urandom_range(0, 3))
          0:       target = int'(key_cfg.sleep_ticks);
          1:       target = int'(key_cfg.restart_ticks);
          2:       target = int'(key_cfg.shutdown_ticks);
          default: target = int'($urandom_range(1, 5));
        endcase
        hold = target + int'($urandom_range(0, 4)) - 2;
        if (hold < 1) hold = 1;
        if (hold > 200) hold = 200;
        send_press(hold);
        sent += hold + 1;
      end
    end
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    idle_on = 1'b1;

    test_disabled_at_boot();
    test_first_release_arms();
    test_hold_windows();
    test_config_changes();
    test_min_thresholds();
    test_max_thresholds();
    for (int p = 0; p < 7; p++) test_random_phase(120, p == 2);
    idle_on = 1'b0;
    test_random_phase(140, 1'b0);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
